[hdl/rss_pkg.sv]
// shared types, constants and register indexes of the recording step sequencer
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

  localparam int STEPS_MAX_DEF = 32;
  localparam int LANES         = 4;
  localparam int SAMPLE_BITS   = 16;
  localparam int OUTQ_DEPTH    = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int CH_W          = 3;
  localparam int KNOB_W        = 6;
  localparam int OFFSET_W      = 7;
  localparam int PHASE_W       = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEPS_KNOB   = 3'd0,
    REG_START_GATE   = 3'd1,
    REG_RECORD_GATE  = 3'd2,
    REG_PRE_MODE     = 3'd3,
    REG_AUTO_STOP    = 3'd4,
    REG_KNOB_VALUE   = 3'd5,
    REG_FORCED_CH    = 3'd6
  } cfg_reg_t;

  typedef logic [LANES-1:0][SAMPLE_BITS-1:0] lanes_t;

  typedef struct packed {
    logic [KNOB_W-1:0]      steps_knob;
    logic                   start_gate;
    logic                   record_gate;
    logic                   pre_mode;
    logic                   auto_stop;
    logic [SAMPLE_BITS-1:0] knob_value;
    logic [CH_W-1:0]        forced_ch;
  } cfg_t;

  typedef struct packed {
    logic                start_lvl;
    logic                record_lvl;
    logic                step_lvl;
    logic                reset_lvl;
    logic [OFFSET_W-1:0] steps_offset;
    logic [PHASE_W-1:0]  phase_inc;
    logic [CH_W-1:0]     in_ch;
    lanes_t              samples;
  } item_t;

  typedef struct packed {
    logic            wa_en;
    logic            wb_en;
    logic            rec;
    logic            run;
    logic [CH_W-1:0] ch;
  } ctrl_flags_t;

  typedef struct packed {
    lanes_t          data;
    logic [CH_W-1:0] cnt;
    logic            rec;
    logic            run;
  } result_t;

endpackage

`default_nettype wire

[hdl/rss_step_mem.sv]
// step store: synchronous memory with valid bits and write-to-read bypass
`timescale 1ns / 1ps
`default_nettype none

module rss_step_mem #(
  parameter int DEPTH = rss_pkg::STEPS_MAX_DEF,
  parameter int W     = rss_pkg::LANES * rss_pkg::SAMPLE_BITS,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     q_r;
  logic [W-1:0]     byp_data_r;
  logic             byp_r;
  logic             q_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r        <= mem[raddr];
      byp_r      <= we && (waddr == raddr);
      byp_data_r <= wdata;
      q_vld_r    <= vld_r[raddr] || (we && (waddr == raddr));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // unwritten entries read as zero
  assign rdata = !q_vld_r ? '0 : (byp_r ? byp_data_r : q_r);

endmodule

`default_nettype wire

[hdl/rss_ctrl.sv]
// sequencer control: run and record flags, phase accumulator, step position
`timescale 1ns / 1ps
`default_nettype none

module rss_ctrl #(
  parameter int STEPS_MAX = rss_pkg::STEPS_MAX_DEF,
  localparam int PW       = $clog2(STEPS_MAX)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 act,
  input  wire rss_pkg::cfg_t        cfg,
  input  wire rss_pkg::item_t       item,
  output rss_pkg::ctrl_flags_t      flags,
  output logic [PW-1:0]             wa_addr,
  output logic [PW-1:0]             wb_addr,
  output logic [PW-1:0]             pos_out,
  output rss_pkg::lanes_t           wa_data,
  output rss_pkg::lanes_t           wb_data,
  output rss_pkg::lanes_t           live
);

  localparam int SW = 10;

  logic [PW-1:0]               pos_r;
  logic [rss_pkg::PHASE_W-1:0] acc_r;
  logic                        run_r;
  logic                        rec_r;
  logic [3:0]                  prev_r;
  rss_pkg::lanes_t             held_r;

  logic [3:0]                  lv;
  logic [3:0]                  rise;
  logic signed [SW-1:0]        cnt_raw;
  logic signed [SW-1:0]        cnt_m1;
  logic [PW-1:0]               last;
  logic [rss_pkg::PHASE_W:0]   sum;
  logic                        run_nxt;
  logic [rss_pkg::PHASE_W-1:0] acc_nxt;
  logic                        adv_a;
  logic                        wrap_a;
  logic [PW-1:0]               pos_a_inc;
  logic [PW-1:0]               pos_a;
  logic                        rec_a;
  logic                        rec_b;
  logic [rss_pkg::CH_W-1:0]    ch_raw;
  logic [rss_pkg::CH_W-1:0]    ch;
  rss_pkg::lanes_t             held_nxt;
  logic                        wrap_b;
  logic [PW-1:0]               pos_b_inc;
  logic [PW-1:0]               pos_b;
  logic                        rec_nxt;
  logic [PW-1:0]               pos_nxt;

  always_comb begin
    lv      = {item.reset_lvl, item.step_lvl, item.record_lvl, item.start_lvl};
    rise    = lv & ~prev_r;

    // step count clamped to 1..STEPS_MAX, kept as count minus one
    cnt_raw = $signed({{(SW-rss_pkg::KNOB_W){1'b0}}, cfg.steps_knob})
            + $signed({{(SW-rss_pkg::OFFSET_W){item.steps_offset[rss_pkg::OFFSET_W-1]}},
                       item.steps_offset});
    cnt_m1  = cnt_raw - $signed(SW'(1));
    if (cnt_raw < $signed(SW'(1))) begin
      last = '0;
    end else if (cnt_raw > $signed(SW'(STEPS_MAX))) begin
      last = PW'(STEPS_MAX - 1);
    end else begin
      last = cnt_m1[PW-1:0];
    end

    run_nxt = cfg.start_gate ? lv[0] : (rise[0] ? ~run_r : run_r);

    // phase advance, uses the flags and samples of the previous tick
    sum     = {1'b0, acc_r} + {1'b0, item.phase_inc};
    adv_a   = run_nxt && sum[rss_pkg::PHASE_W];
    if (!run_nxt) begin
      acc_nxt = acc_r;
    end else if (sum[rss_pkg::PHASE_W]) begin
      acc_nxt = '0;
    end else begin
      acc_nxt = sum[rss_pkg::PHASE_W-1:0];
    end
    wrap_a    = pos_r >= last;
    pos_a_inc = wrap_a ? '0 : pos_r + 1'b1;
    pos_a     = adv_a ? pos_a_inc : pos_r;
    rec_a     = (adv_a && wrap_a && cfg.auto_stop) ? 1'b0 : rec_r;

    rec_b = cfg.record_gate ? lv[1] : (rise[1] ? ~rec_a : rec_a);

    ch_raw = (cfg.forced_ch != '0) ? cfg.forced_ch : item.in_ch;
    ch     = (ch_raw > rss_pkg::CH_W'(rss_pkg::LANES)) ? rss_pkg::CH_W'(rss_pkg::LANES)
                                                       : ch_raw;
    for (int c = 0; c < rss_pkg::LANES; c++) begin
      if (ch == '0) begin
        held_nxt[c] = cfg.knob_value;
      end else if (ch == rss_pkg::CH_W'(1)) begin
        held_nxt[c] = item.samples[0];
      end else if (rss_pkg::CH_W'(c) < ch) begin
        held_nxt[c] = item.samples[c];
      end else begin
        held_nxt[c] = '0;
      end
    end

    // manual step advance, uses this tick's flags and samples
    wrap_b    = pos_a >= last;
    pos_b_inc = wrap_b ? '0 : pos_a + 1'b1;
    pos_b     = rise[2] ? pos_b_inc : pos_a;
    rec_nxt   = (rise[2] && wrap_b && cfg.auto_stop) ? 1'b0 : rec_b;

    pos_nxt = rise[3] ? '0 : pos_b;
  end

  always_comb begin
    flags.wa_en = adv_a && rec_r;
    flags.wb_en = rise[2] && rec_b;
    flags.rec   = rec_nxt;
    flags.run   = run_nxt;
    flags.ch    = ch;
    wa_addr     = cfg.pre_mode ? pos_r : pos_a_inc;
    wb_addr     = cfg.pre_mode ? pos_a : pos_b_inc;
    wa_data     = held_r;
    wb_data     = held_nxt;
    live        = held_nxt;
    pos_out     = pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      acc_r  <= '0;
      run_r  <= 1'b0;
      rec_r  <= 1'b0;
      prev_r <= '0;
      held_r <= '0;
    end else if (act) begin
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      run_r  <= run_nxt;
      rec_r  <= rec_nxt;
      prev_r <= lv;
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/rss_outq.sv]
// result queue between the pipeline and the output channel
`timescale 1ns / 1ps
`default_nettype none

module rss_outq #(
  parameter int W     = 8,
  parameter int DEPTH = rss_pkg::OUTQ_DEPTH,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic      [W-1:0] pop_data,
  output logic              not_empty
);

  logic [W-1:0]  buf_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data  = buf_r[rd_ptr_r];
  assign not_empty = (count_r != '0);

endmodule

`default_nettype wire

[hdl/recording_step_sequencer_core.sv]
// recording step sequencer: top level with pipeline, configuration and output
// channels
//   input channel in_valid / in_stall carries one sample tick per request:
//   control levels, step offset, phase increment, channel count and samples.
//   output channel out_valid / out_stall returns one result request per tick:
//   four lanes, channel count, step index, recording and running flags.
//   configuration is a write port (cfg_we, cfg_index, cfg_wdata), no wait.
// store writes: each tick may write the step store twice (phase advance and
//   manual step) through its single write port.
// pipeline: an accepted request passes stages s1, s2 and s3, then waits in the result queue for out_valid.
// reset: flags, position, phase and registers return to defaults; the store's
//   per-entry valid bits clear at once, so there is no clearing pass.
// stall: a four-deep result queue absorbs output stalls; the input stalls in
//   the cycle after each acceptance and while four results are outstanding.
`timescale 1ns / 1ps
`default_nettype none

module recording_step_sequencer_core #(
  parameter int STEPS_MAX = rss_pkg::STEPS_MAX_DEF,
  localparam int PW       = $clog2(STEPS_MAX)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_start_level,
  input  wire logic                               in_record_level,
  input  wire logic                               in_step_level,
  input  wire logic                               in_reset_level,
  input  wire logic signed [rss_pkg::OFFSET_W-1:0] in_steps_offset,
  input  wire logic [rss_pkg::PHASE_W-1:0]        in_phase_increment,
  input  wire logic [rss_pkg::CH_W-1:0]           in_input_channels,
  input  wire logic signed [rss_pkg::SAMPLE_BITS-1:0] in_sample_0,
  input  wire logic signed [rss_pkg::SAMPLE_BITS-1:0] in_sample_1,
  input  wire logic signed [rss_pkg::SAMPLE_BITS-1:0] in_sample_2,
  input  wire logic signed [rss_pkg::SAMPLE_BITS-1:0] in_sample_3,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [rss_pkg::SAMPLE_BITS-1:0]  out_0,
  output logic signed [rss_pkg::SAMPLE_BITS-1:0]  out_1,
  output logic signed [rss_pkg::SAMPLE_BITS-1:0]  out_2,
  output logic signed [rss_pkg::SAMPLE_BITS-1:0]  out_3,
  output logic [rss_pkg::CH_W-1:0]                out_count,
  output logic [PW-1:0]                           out_step_index,
  output logic                                    out_is_recording,
  output logic                                    out_is_running,
  input  wire logic                               cfg_we,
  input  wire logic [rss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int QW  = $bits(rss_pkg::result_t) + PW;
  localparam int PNW = $clog2(rss_pkg::OUTQ_DEPTH + 1);

  rss_pkg::cfg_t        cfg_r;
  rss_pkg::item_t       item_r;
  logic                 s1_v_r;
  logic                 accept;

  rss_pkg::ctrl_flags_t flags;
  logic [PW-1:0]        wa_addr;
  logic [PW-1:0]        wb_addr;
  logic [PW-1:0]        pos;
  rss_pkg::lanes_t      wa_data;
  rss_pkg::lanes_t      wb_data;
  rss_pkg::lanes_t      live;

  logic                 s2_v_r;
  logic                 s2_wb_en_r;
  logic [PW-1:0]        s2_wb_addr_r;
  rss_pkg::lanes_t      s2_wb_data_r;
  logic [PW-1:0]        s2_pos_r;
  rss_pkg::ctrl_flags_t s2_flags_r;
  rss_pkg::lanes_t      s2_live_r;

  logic                 s3_v_r;
  logic [PW-1:0]        s3_pos_r;
  rss_pkg::ctrl_flags_t s3_flags_r;
  rss_pkg::lanes_t      s3_live_r;

  logic                 mem_we;
  logic [PW-1:0]        mem_waddr;
  rss_pkg::lanes_t      mem_wdata;
  rss_pkg::lanes_t      mem_rdata;

  rss_pkg::result_t     res;
  rss_pkg::result_t     res_q;
  logic [QW-1:0]        q_pop_data;
  logic                 pop;
  logic [PNW-1:0]       pend_r;
  logic [PNW-1:0]       pend_nxt;

  assign in_stall = s1_v_r || (pend_r == PNW'(rss_pkg::OUTQ_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steps_knob  <= rss_pkg::KNOB_W'(16);
      cfg_r.start_gate  <= 1'b0;
      cfg_r.record_gate <= 1'b0;
      cfg_r.pre_mode    <= 1'b0;
      cfg_r.auto_stop   <= 1'b1;
      cfg_r.knob_value  <= '0;
      cfg_r.forced_ch   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rss_pkg::REG_STEPS_KNOB:  cfg_r.steps_knob  <= cfg_wdata[rss_pkg::KNOB_W-1:0];
        rss_pkg::REG_START_GATE:  cfg_r.start_gate  <= cfg_wdata[0];
        rss_pkg::REG_RECORD_GATE: cfg_r.record_gate <= cfg_wdata[0];
        rss_pkg::REG_PRE_MODE:    cfg_r.pre_mode    <= cfg_wdata[0];
        rss_pkg::REG_AUTO_STOP:   cfg_r.auto_stop   <= cfg_wdata[0];
        rss_pkg::REG_KNOB_VALUE:  cfg_r.knob_value  <= cfg_wdata[rss_pkg::SAMPLE_BITS-1:0];
        rss_pkg::REG_FORCED_CH:   cfg_r.forced_ch   <= cfg_wdata[rss_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.start_lvl    <= in_start_level;
      item_r.record_lvl   <= in_record_level;
      item_r.step_lvl     <= in_step_level;
      item_r.reset_lvl    <= in_reset_level;
      item_r.steps_offset <= in_steps_offset;
      item_r.phase_inc    <= in_phase_increment;
      item_r.in_ch        <= in_input_channels;
      item_r.samples      <= {in_sample_3, in_sample_2, in_sample_1, in_sample_0};
    end
  end

  rss_ctrl #(
    .STEPS_MAX (STEPS_MAX)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .act     (s1_v_r),
    .cfg     (cfg_r),
    .item    (item_r),
    .flags   (flags),
    .wa_addr (wa_addr),
    .wb_addr (wb_addr),
    .pos_out (pos),
    .wa_data (wa_data),
    .wb_data (wb_data),
    .live    (live)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_wb_en_r   <= flags.wb_en;
      s2_wb_addr_r <= wb_addr;
      s2_wb_data_r <= wb_data;
      s2_pos_r     <= pos;
      s2_flags_r   <= flags;
      s2_live_r    <= live;
    end
    if (s2_v_r) begin
      s3_pos_r   <= s2_pos_r;
      s3_flags_r <= s2_flags_r;
      s3_live_r  <= s2_live_r;
    end
  end

  // phase-advance write while s1 is valid, manual-step write while s2 is valid
  always_comb begin
    mem_we    = (s1_v_r && flags.wa_en) || (s2_v_r && s2_wb_en_r);
    mem_waddr = s1_v_r ? wa_addr : s2_wb_addr_r;
    mem_wdata = s1_v_r ? wa_data : s2_wb_data_r;
  end

  rss_step_mem #(
    .DEPTH (STEPS_MAX),
    .W     ($bits(rss_pkg::lanes_t))
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (s2_v_r),
    .raddr (s2_pos_r),
    .rdata (mem_rdata)
  );

  // live overlay while recording, unused lanes forced to zero
  always_comb begin
    res.cnt = (s3_flags_r.ch == '0) ? rss_pkg::CH_W'(1) : s3_flags_r.ch;
    res.rec = s3_flags_r.rec;
    res.run = s3_flags_r.run;
    for (int c = 0; c < rss_pkg::LANES; c++) begin
      if (rss_pkg::CH_W'(c) >= res.cnt) begin
        res.data[c] = '0;
      end else if (s3_flags_r.rec && (rss_pkg::CH_W'(c) < s3_flags_r.ch)) begin
        res.data[c] = s3_live_r[c];
      end else begin
        res.data[c] = mem_rdata[c];
      end
    end
  end

  rss_outq #(
    .W     (QW),
    .DEPTH (rss_pkg::OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_v_r),
    .push_data ({res, s3_pos_r}),
    .pop       (pop),
    .pop_data  (q_pop_data),
    .not_empty (out_valid)
  );

  assign {res_q, out_step_index} = q_pop_data;
  assign out_0            = res_q.data[0];
  assign out_1            = res_q.data[1];
  assign out_2            = res_q.data[2];
  assign out_3            = res_q.data[3];
  assign out_count        = res_q.cnt;
  assign out_is_recording = res_q.rec;
  assign out_is_running   = res_q.run;

  // requests accepted and not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (accept && !pop) begin
      pend_nxt = pend_r + 1'b1;
    end else if (pop && !accept) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

`ifndef SYNTHESIS
  a_one_request_per_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("request accepted in consecutive cycles");

  a_single_write_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_v_r && s2_v_r))
    else $error("both store writes fall in one cycle");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PNW'(rss_pkg::OUTQ_DEPTH))
    else $error("more requests outstanding than the result queue holds");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |=> out_valid)
    else $error("result pushed but queue shows empty");
`endif

endmodule

`default_nettype wire

[dv/recording_step_sequencer_core_test.sv]
// self-checking testbench of the recording step sequencer core with a tick scoreboard
`timescale 1ns / 1ps

typedef struct packed {
  logic [3:0][15:0] lanes;
  logic [2:0]       count;
  logic [4:0]       index;
  logic             rec;
  logic             run;
} seq_result_t;

class seq_scoreboard;
  rss_pkg::cfg_t    cfg;
  logic [3:0][15:0] store [32];
  logic [3:0][15:0] held;
  int               pos;
  logic [31:0]      acc;
  bit               running;
  bit               recording;
  logic [3:0]       prev_lv;
  seq_result_t      expected_q [$];
  int               fails;

  function new();
    for (int s = 0; s < 32; s++) store[s] = '0;
    held      = '0;
    pos       = 0;
    acc       = '0;
    running   = 1'b0;
    recording = 1'b0;
    prev_lv   = '0;
    fails     = 0;
    cfg.steps_knob  = 6'd16;
    cfg.start_gate  = 1'b0;
    cfg.record_gate = 1'b0;
    cfg.pre_mode    = 1'b0;
    cfg.auto_stop   = 1'b1;
    cfg.knob_value  = '0;
    cfg.forced_ch   = '0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [15:0] v);
    case (idx)
      rss_pkg::REG_STEPS_KNOB: cfg.steps_knob = v[5:0];
      rss_pkg::REG_START_GATE: cfg.start_gate = v[0];
      rss_pkg::REG_RECORD_GATE: cfg.record_gate = v[0];
      rss_pkg::REG_PRE_MODE: cfg.pre_mode = v[0];
      rss_pkg::REG_AUTO_STOP: cfg.auto_stop = v[0];
      rss_pkg::REG_KNOB_VALUE: cfg.knob_value = v;
      rss_pkg::REG_FORCED_CH: cfg.forced_ch = v[2:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function int step_count(logic [6:0] off);
    int n;
    n = int'(cfg.steps_knob) + int'($signed(off));
    if (n < 1) n = 1;
    if (n > 32) n = 32;
    return n;
  endfunction

  function void advance(int steps);
    bit wrapped;
    wrapped = 1'b0;
    if (cfg.pre_mode && recording) store[pos] = held;
    pos++;
    if (pos > steps - 1) begin
      pos = 0;
      wrapped = 1'b1;
    end
    if (!cfg.pre_mode && recording) store[pos] = held;
    if (wrapped && cfg.auto_stop) recording = 1'b0;
  endfunction

  function void note_request(rss_pkg::item_t t);
    logic [3:0]       lv;
    logic [3:0]       rise;
    logic [32:0]      sum;
    logic [3:0][15:0] lanes;
    int               steps;
    int               ch;
    int               cnt;
    seq_result_t      r;
    lv = {t.reset_lvl, t.step_lvl, t.record_lvl, t.start_lvl};
    rise = lv & ~prev_lv;
    prev_lv = lv;
    steps = step_count(t.steps_offset);
    if (cfg.start_gate) running = lv[0];
    else if (rise[0]) running = !running;
    if (running) begin
      sum = {1'b0, acc} + {1'b0, t.phase_inc};
      if (sum[32]) begin
        advance(steps);
        acc = '0;
      end else begin
        acc = sum[31:0];
      end
    end
    if (cfg.record_gate) recording = lv[1];
    else if (rise[1]) recording = !recording;
    ch = (cfg.forced_ch != 0) ? int'(cfg.forced_ch) : int'(t.in_ch);
    if (ch > 4) ch = 4;
    for (int c = 0; c < 4; c++) begin
      if (ch == 0) held[c] = cfg.knob_value;
      else if (ch == 1) held[c] = t.samples[0];
      else if (c < ch) held[c] = t.samples[c];
      else held[c] = '0;
    end
    if (rise[2]) advance(steps);
    if (rise[3]) pos = 0;
    lanes = store[pos];
    if (recording)
      for (int c = 0; c < ch; c++) lanes[c] = held[c];
    cnt = (ch != 0) ? ch : 1;
    for (int c = 0; c < 4; c++) r.lanes[c] = (c < cnt) ? lanes[c] : '0;
    r.count = 3'(cnt);
    r.index = 5'(pos);
    r.rec   = recording;
    r.run   = running;
    expected_q.push_back(r);
  endfunction

  function void match(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0h actual %0h", field, want, got);
      fails++;
    end
  endfunction

  function void check_result(seq_result_t got);
    seq_result_t want;
    if (expected_q.size() == 0) begin
      $error("result with no request outstanding");
      fails++;
      return;
    end
    want = expected_q.pop_front();
    for (int k = 0; k < 4; k++)
      match($sformatf("out_%0d", k), 32'(want.lanes[k]), 32'(got.lanes[k]));
    match("out_count", 32'(want.count), 32'(got.count));
    match("out_step_index", 32'(want.index), 32'(got.index));
    match("out_is_recording", 32'(want.rec), 32'(got.rec));
    match("out_is_running", 32'(want.run), 32'(got.run));
  endfunction
endclass

module recording_step_sequencer_core_test;

  localparam int         NUM_PHASES     = 8;
  localparam int         RAND_PER_PHASE = 100;
  localparam int         PRESS_PHASE    = 4;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         CYCLE_LIMIT    = 300000;
  localparam logic [2:0] REG_UNUSED     = 3'd7;

  logic                clk                = 1'b0;
  logic                rst_n              = 1'b0;
  logic                in_valid           = 1'b0;
  logic                in_stall;
  logic                in_start_level     = 1'b0;
  logic                in_record_level    = 1'b0;
  logic                in_step_level      = 1'b0;
  logic                in_reset_level     = 1'b0;
  logic signed [6:0]   in_steps_offset    = '0;
  logic [31:0]         in_phase_increment = '0;
  logic [2:0]          in_input_channels  = '0;
  logic signed [15:0]  in_sample_0        = '0;
  logic signed [15:0]  in_sample_1        = '0;
  logic signed [15:0]  in_sample_2        = '0;
  logic signed [15:0]  in_sample_3        = '0;
  logic                out_valid;
  logic                out_stall          = 1'b0;
  logic signed [15:0]  out_0;
  logic signed [15:0]  out_1;
  logic signed [15:0]  out_2;
  logic signed [15:0]  out_3;
  logic [2:0]          out_count;
  logic [4:0]          out_step_index;
  logic                out_is_recording;
  logic                out_is_running;
  logic                cfg_we             = 1'b0;
  logic [2:0]          cfg_index          = '0;
  logic [15:0]         cfg_wdata          = '0;

  int                  send_idle_pct      = 0;
  int                  stall_pct          = 0;
  bit                  hold_armed         = 1'b0;
  int                  cycle_count        = 0;
  logic                lv_start           = 1'b0;
  logic                lv_record          = 1'b0;
  logic                lv_step            = 1'b0;
  logic                lv_reset           = 1'b0;
  seq_scoreboard       sb                 = new();

  recording_step_sequencer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_level    (in_start_level),
    .in_record_level   (in_record_level),
    .in_step_level     (in_step_level),
    .in_reset_level    (in_reset_level),
    .in_steps_offset   (in_steps_offset),
    .in_phase_increment(in_phase_increment),
    .in_input_channels (in_input_channels),
    .in_sample_0       (in_sample_0),
    .in_sample_1       (in_sample_1),
    .in_sample_2       (in_sample_2),
    .in_sample_3       (in_sample_3),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_0             (out_0),
    .out_1             (out_1),
    .out_2             (out_2),
    .out_3             (out_3),
    .out_count         (out_count),
    .out_step_index    (out_step_index),
    .out_is_recording  (out_is_recording),
    .out_is_running    (out_is_running),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // accepted requests and results, sampled with their pre-edge values
  always @(posedge clk) begin : monitor
    rss_pkg::item_t seen;
    seq_result_t    got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        seen.start_lvl    = in_start_level;
        seen.record_lvl   = in_record_level;
        seen.step_lvl     = in_step_level;
        seen.reset_lvl    = in_reset_level;
        seen.steps_offset = in_steps_offset;
        seen.phase_inc    = in_phase_increment;
        seen.in_ch        = in_input_channels;
        seen.samples      = {in_sample_3, in_sample_2, in_sample_1, in_sample_0};
        sb.note_request(seen);
      end
      if (out_valid && !out_stall) begin
        got.lanes = {out_3, out_2, out_1, out_0};
        got.count = out_count;
        got.index = out_step_index;
        got.rec   = out_is_recording;
        got.run   = out_is_running;
        sb.check_result(got);
      end
    end
  end

  initial begin : receiver
    int held_off;
    held_off = 0;
    forever begin
      @(posedge clk);
      if (hold_armed && held_off < HOLD_CYCLES) begin
        out_stall <= 1'b1;
        held_off++;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_item(input rss_pkg::item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_start_level     <= t.start_lvl;
    in_record_level    <= t.record_lvl;
    in_step_level      <= t.step_lvl;
    in_reset_level     <= t.reset_lvl;
    in_steps_offset    <= t.steps_offset;
    in_phase_increment <= t.phase_inc;
    in_input_channels  <= t.in_ch;
    in_sample_0        <= t.samples[0];
    in_sample_1        <= t.samples[1];
    in_sample_2        <= t.samples[2];
    in_sample_3        <= t.samples[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_config(input rss_pkg::cfg_t c);
    write_reg(rss_pkg::REG_STEPS_KNOB, 16'(c.steps_knob));
    write_reg(rss_pkg::REG_START_GATE, 16'(c.start_gate));
    write_reg(rss_pkg::REG_RECORD_GATE, 16'(c.record_gate));
    write_reg(rss_pkg::REG_PRE_MODE, 16'(c.pre_mode));
    write_reg(rss_pkg::REG_AUTO_STOP, 16'(c.auto_stop));
    write_reg(rss_pkg::REG_KNOB_VALUE, c.knob_value);
    write_reg(rss_pkg::REG_FORCED_CH, 16'(c.forced_ch));
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic rss_pkg::cfg_t pick_config(int ph);
    rss_pkg::cfg_t c;
    c.steps_knob  = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(32, 1));
    c.start_gate  = 1'($urandom);
    c.record_gate = 1'($urandom);
    c.pre_mode    = 1'($urandom);
    c.auto_stop   = 1'($urandom);
    c.knob_value  = 16'($urandom);
    c.forced_ch   = ($urandom_range(2) == 0) ? 3'($urandom) : 3'd0;
    case (ph)
      1: c = '{steps_knob: 6'd1, start_gate: 1'b0, record_gate: 1'b0, pre_mode: 1'b1,
               auto_stop: 1'b0, knob_value: 16'h8000, forced_ch: 3'd1};
      2: c = '{steps_knob: 6'd32, start_gate: 1'b1, record_gate: 1'b1, pre_mode: 1'b0,
               auto_stop: 1'b1, knob_value: 16'h7fff, forced_ch: 3'd4};
      3: begin
        c.steps_knob = 6'd0;
        c.start_gate = 1'b1;
        c.record_gate = 1'b0;
        c.pre_mode = 1'b1;
        c.forced_ch = 3'd7;
      end
      4: begin
        c.steps_knob = 6'd63;
        c.start_gate = 1'b0;
        c.record_gate = 1'b1;
        c.auto_stop = 1'b0;
        c.forced_ch = 3'd0;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic rss_pkg::item_t make_tick(logic st, logic rc, logic sp, logic rs,
                                               logic [6:0] off, logic [31:0] inc,
                                               logic [2:0] ch, logic [15:0] s0,
                                               logic [15:0] s1, logic [15:0] s2,
                                               logic [15:0] s3);
    rss_pkg::item_t t;
    t.start_lvl    = st;
    t.record_lvl   = rc;
    t.step_lvl     = sp;
    t.reset_lvl    = rs;
    t.steps_offset = off;
    t.phase_inc    = inc;
    t.in_ch        = ch;
    t.samples      = {s3, s2, s1, s0};
    return t;
  endfunction

  // control levels drift slowly so that runs and recordings last a while
  task automatic random_tick(output rss_pkg::item_t t);
    if ($urandom_range(99) < 12) lv_start = ~lv_start;
    if ($urandom_range(99) < 10) lv_record = ~lv_record;
    if ($urandom_range(99) < 20) lv_step = ~lv_step;
    if ($urandom_range(99) < 5) lv_reset = ~lv_reset;
    t.start_lvl  = lv_start;
    t.record_lvl = lv_record;
    t.step_lvl   = lv_step;
    t.reset_lvl  = lv_reset;
    case ($urandom_range(9))
      0: t.steps_offset = 7'($urandom);
      1, 2: t.steps_offset = 7'($signed($urandom_range(8)) - 4);
      default: t.steps_offset = '0;
    endcase
    case ($urandom_range(7))
      0: t.phase_inc = '0;
      1: t.phase_inc = '1;
      2: t.phase_inc = 32'h8000_0000 | 32'($urandom);
      3, 4: t.phase_inc = 32'($urandom);
      default: t.phase_inc = 32'($urandom) >> $urandom_range(4, 1);
    endcase
    t.in_ch = 3'($urandom);
    for (int k = 0; k < 4; k++) t.samples[k] = 16'($urandom);
  endtask

  task automatic directed_ticks();
    send_item(make_tick(0, 0, 0, 0, 7'd0, 32'h0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0));
    send_item(make_tick(1, 0, 0, 0, 7'd0, 32'hffff_ffff, 3'd4,
                        16'h7fff, 16'h8000, 16'h0001, 16'hffff));
    send_item(make_tick(1, 0, 0, 0, 7'd0, 32'h1, 3'd4, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0));
    send_item(make_tick(1, 1, 0, 0, 7'd0, 32'h0, 3'd2, 16'h8000, 16'h7fff, 16'haaaa, 16'h5555));
    send_item(make_tick(1, 1, 0, 0, 7'd0, 32'h8000_0000, 3'd1, 16'h7fff, 16'h0, 16'h0, 16'h0));
    send_item(make_tick(1, 1, 0, 0, 7'd0, 32'h8000_0000, 3'd3,
                        16'h0101, 16'h0202, 16'h0303, 16'h0404));
    send_item(make_tick(1, 1, 1, 0, 7'd63, 32'h0, 3'd4, 16'hffff, 16'h8000, 16'h7fff, 16'h0));
    // index beyond a one-step count, next advance wraps and ends recording
    send_item(make_tick(1, 1, 0, 0, 7'h40, 32'h0, 3'd4, 16'h1111, 16'h2222, 16'h3333, 16'h4444));
    send_item(make_tick(1, 1, 1, 0, 7'h40, 32'h0, 3'd4, 16'h5555, 16'h6666, 16'h7777, 16'h8888));
    send_item(make_tick(1, 1, 0, 1, 7'd0, 32'h0, 3'd2, 16'h0, 16'h0, 16'h0, 16'h0));
    send_item(make_tick(1, 0, 0, 0, 7'h60, 32'h4000_0000, 3'd7,
                        16'hcafe, 16'hbeef, 16'hf00d, 16'h0bad));
    send_item(make_tick(1, 1, 0, 0, 7'h60, 32'h4000_0000, 3'd7,
                        16'h8001, 16'h7ffe, 16'h00ff, 16'hff00));
    // recording with no channels, out_0 still shows the stored step
    send_item(make_tick(1, 1, 1, 0, 7'd32, 32'hc000_0000, 3'd0,
                        16'h4321, 16'h0, 16'h0, 16'h0));
    send_item(make_tick(0, 1, 0, 0, 7'd32, 32'hffff_ffff, 3'd5,
                        16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_item(make_tick(1, 0, 1, 0, 7'd0, 32'hffff_ffff, 3'd6,
                        16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_item(make_tick(0, 1, 0, 0, 7'h7f, 32'h0, 3'd3, 16'h0aaa, 16'h0bbb, 16'h0ccc, 16'h0ddd));
    send_item(make_tick(0, 1, 1, 0, 7'h7f, 32'h0, 3'd1, 16'hffff, 16'h0, 16'h0, 16'h0));
    send_item(make_tick(1, 1, 0, 1, 7'd1, 32'h7fff_ffff, 3'd2, 16'h1, 16'h2, 16'h3, 16'h4));
    send_item(make_tick(1, 0, 1, 0, 7'd1, 32'h8000_0001, 3'd4,
                        16'hfffe, 16'h0002, 16'h8000, 16'h7fff));
  endtask

  initial begin : main
    rss_pkg::item_t t;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        directed_ticks();
      end else begin
        wait_drained();
        apply_config(pick_config(ph));
      end
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 56;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 56;
        end
        default: begin
          send_idle_pct = 9;
          stall_pct = 9;
        end
      endcase
      // long receiver hold-off while requests keep coming
      if (ph == PRESS_PHASE) hold_armed = 1'b1;
      repeat (RAND_PER_PHASE) begin
        random_tick(t);
        send_item(t);
      end
    end
    stall_pct = 0;
    wait_drained();
    if (sb.fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
